[rtl/awpg_pkg.sv]
// shared types and constants of the area weighted priority grid
// used by awpg_ctrl, awpg_dp and area_weighted_priority_grid_unit
`default_nettype none

package awpg_pkg;

    localparam int WEIGHT_W  = 48;   // cell weight, Q32.16
    localparam int PRIO_W    = 24;   // priority, Q8.16
    localparam int Q_W       = 17;   // ratio, Q1.16
    localparam int FRAC_W    = 16;
    localparam int GEO_W     = 24;   // signed scene coordinate math
    localparam int DIM_W     = 13;
    localparam int GRID_W    = 5;
    localparam int COORD_W   = 16;
    localparam int SEL_W     = 8;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int DIV_STEPS = 16;
    localparam int DCNT_W    = 5;
    localparam int PART_W    = 16;
    localparam int MUL_PARTS = 3;    // WEIGHT_W / PART_W
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [Q_W-1:0] ONE_Q = 17'h10000;

    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_RECT = 2'd1;
    localparam logic [OP_W-1:0] OP_CELL = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] REG_CELL_WIDTH  = 2'd0;
    localparam logic [1:0] REG_CELL_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GRID_COLS   = 2'd2;
    localparam logic [1:0] REG_GRID_ROWS   = 2'd3;

    typedef struct packed {
        logic clr;
        logic start;
        logic rd;
        logic area;
        logic dstart;
        logic dstep;
        logic mstep;
        logic wb;
        logic next;
        logic fstart;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            clr_last;
        logic            out_of_range;
        logic            empty_grid;
        logic            overlap;
        logic            div_done;
        logic            mul_last;
        logic            last_cell;
        logic            total_zero;
        logic            out_free;
    } t_sts;

endpackage

`default_nettype wire

[rtl/area_weighted_priority_grid_unit.sv]
// Area weighted priority grid: top level with configuration registers.
// Input channel i_valid/o_stall carries one item (add, query rectangle or
// query cell); output channel o_valid/i_stall returns one item each.
// Registers sit on an APB-style port: cell_width 0x0, cell_height 0x4,
// grid_columns 0x8, grid_rows 0xC; write them only while no item is in flight.
// After reset the block clears its MAX_COLUMNS*MAX_ROWS weight memory, one
// entry a cycle, with o_stall high until the clearing pass is done.
// One item at a time: a cell outside the item's window goes through read, area
// and next; an overlapped cell of an add or query rectangle goes through read, area, a 16 step
// restoring divide for the overlap ratio, 1 or 3 multiply slices, write back;
// a ratio that saturates at 1.0 skips the divide steps.
// A query with a nonzero total runs the same divide for the final share.
// A cell out of range or opcode 3 goes straight to the result.
// The next item can be taken in the cycle after the result loads.
// The result waits in an output register; while the receiver stalls, the
// block still takes the next item and runs it up to its result, then waits.
// Depends on awpg_pkg, awpg_ctrl and awpg_dp.
`default_nettype none

module area_weighted_priority_grid_unit #(
    parameter int MAX_COLUMNS = 16,
    parameter int MAX_ROWS    = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [awpg_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [awpg_pkg::PDATA_W-1:0]        pwdata,
    output logic [awpg_pkg::PDATA_W-1:0]             prdata,
    output logic                                     pready,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [awpg_pkg::OP_W-1:0]           i_opcode,
    input  wire logic signed [awpg_pkg::COORD_W-1:0] i_rect_x,
    input  wire logic signed [awpg_pkg::COORD_W-1:0] i_rect_y,
    input  wire logic [awpg_pkg::COORD_W-1:0]        i_rect_width,
    input  wire logic [awpg_pkg::COORD_W-1:0]        i_rect_height,
    input  wire logic [awpg_pkg::PRIO_W-1:0]         i_priority_req,
    input  wire logic [awpg_pkg::SEL_W-1:0]          i_cell_row,
    input  wire logic [awpg_pkg::SEL_W-1:0]          i_cell_col,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [awpg_pkg::Q_W-1:0]                 o_offset,
    output logic [awpg_pkg::ST_W-1:0]                o_status
);

    logic [awpg_pkg::DIM_W-1:0]  r_cell_width;
    logic [awpg_pkg::DIM_W-1:0]  r_cell_height;
    logic [awpg_pkg::GRID_W-1:0] r_grid_columns;
    logic [awpg_pkg::GRID_W-1:0] r_grid_rows;
    logic                        cfg_wr;
    awpg_pkg::t_cmd              cmd;
    awpg_pkg::t_sts              sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width   <= awpg_pkg::DIM_W'(256);
            r_cell_height  <= awpg_pkg::DIM_W'(256);
            r_grid_columns <= awpg_pkg::GRID_W'(16);
            r_grid_rows    <= awpg_pkg::GRID_W'(16);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                awpg_pkg::REG_CELL_WIDTH:  r_cell_width   <= pwdata[awpg_pkg::DIM_W-1:0];
                awpg_pkg::REG_CELL_HEIGHT: r_cell_height  <= pwdata[awpg_pkg::DIM_W-1:0];
                awpg_pkg::REG_GRID_COLS:   r_grid_columns <= pwdata[awpg_pkg::GRID_W-1:0];
                awpg_pkg::REG_GRID_ROWS:   r_grid_rows    <= pwdata[awpg_pkg::GRID_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            awpg_pkg::REG_CELL_WIDTH:  prdata = awpg_pkg::PDATA_W'(r_cell_width);
            awpg_pkg::REG_CELL_HEIGHT: prdata = awpg_pkg::PDATA_W'(r_cell_height);
            awpg_pkg::REG_GRID_COLS:   prdata = awpg_pkg::PDATA_W'(r_grid_columns);
            awpg_pkg::REG_GRID_ROWS:   prdata = awpg_pkg::PDATA_W'(r_grid_rows);
            default:                   prdata = '0;
        endcase
    end

    awpg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    awpg_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cell_width   (r_cell_width),
        .i_cell_height  (r_cell_height),
        .i_grid_columns (r_grid_columns),
        .i_grid_rows    (r_grid_rows),
        .i_opcode       (i_opcode),
        .i_rect_x       (i_rect_x),
        .i_rect_y       (i_rect_y),
        .i_rect_width   (i_rect_width),
        .i_rect_height  (i_rect_height),
        .i_priority_req (i_priority_req),
        .i_cell_row     (i_cell_row),
        .i_cell_col     (i_cell_col),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_offset       (o_offset),
        .o_status       (o_status)
    );

    // an accepted item keeps the input side busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accepting an item");

    // error status always comes with a zero share
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != awpg_pkg::ST_OK) |-> (o_offset == '0))
        else $error("nonzero offset with error status");

    // share never exceeds one
    a_share_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_offset <= awpg_pkg::ONE_Q))
        else $error("offset above 1.0");

endmodule

`default_nettype wire

[rtl/awpg_ctrl.sv]
// sequencer of the priority grid: clearing pass, cell walk, divides, result
// depends on awpg_pkg for the command and status structs
`default_nettype none

module awpg_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire awpg_pkg::t_sts i_sts,
    output awpg_pkg::t_cmd     o_cmd
);

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_CHECK = 13'b0000000000100,
        S_RD    = 13'b0000000001000,
        S_AREA  = 13'b0000000010000,
        S_DST   = 13'b0000000100000,
        S_DIV   = 13'b0000001000000,
        S_MUL   = 13'b0000010000000,
        S_WB    = 13'b0000100000000,
        S_NEXT  = 13'b0001000000000,
        S_FIN   = 13'b0010000000000,
        S_FDIV  = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.op == awpg_pkg::OP_NONE || i_sts.out_of_range) begin
                    n_state = S_OUT;
                end else if (i_sts.empty_grid) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_AREA;
            end
            S_AREA: begin
                o_cmd.area = 1'b1;
                if (i_sts.overlap && (i_sts.op == awpg_pkg::OP_ADD ||
                                      i_sts.op == awpg_pkg::OP_RECT)) begin
                    n_state = S_DST;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_DST: begin
                o_cmd.dstart = 1'b1;
                n_state      = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_MUL;
                end else begin
                    o_cmd.dstep = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mstep = 1'b1;
                if (i_sts.mul_last) n_state = S_WB;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = S_NEXT;
            end
            S_NEXT: begin
                o_cmd.next = 1'b1;
                n_state    = i_sts.last_cell ? S_FIN : S_RD;
            end
            S_FIN: begin
                if (i_sts.op == awpg_pkg::OP_ADD || i_sts.total_zero) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.fstart = 1'b1;
                    n_state      = S_FDIV;
                end
            end
            S_FDIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.dstep = 1'b1;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

[rtl/awpg_dp.sv]
// datapath of the priority grid: weight memory, overlap math, shared divider,
// multiplier, running sums and output register; depends on awpg_pkg
`default_nettype none

module awpg_dp #(
    parameter int MAX_COLUMNS = 16,
    parameter int MAX_ROWS    = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire awpg_pkg::t_cmd                      i_cmd,
    output awpg_pkg::t_sts                           o_sts,
    input  wire logic [awpg_pkg::DIM_W-1:0]          i_cell_width,
    input  wire logic [awpg_pkg::DIM_W-1:0]          i_cell_height,
    input  wire logic [awpg_pkg::GRID_W-1:0]         i_grid_columns,
    input  wire logic [awpg_pkg::GRID_W-1:0]         i_grid_rows,
    input  wire logic [awpg_pkg::OP_W-1:0]           i_opcode,
    input  wire logic signed [awpg_pkg::COORD_W-1:0] i_rect_x,
    input  wire logic signed [awpg_pkg::COORD_W-1:0] i_rect_y,
    input  wire logic [awpg_pkg::COORD_W-1:0]        i_rect_width,
    input  wire logic [awpg_pkg::COORD_W-1:0]        i_rect_height,
    input  wire logic [awpg_pkg::PRIO_W-1:0]         i_priority_req,
    input  wire logic [awpg_pkg::SEL_W-1:0]          i_cell_row,
    input  wire logic [awpg_pkg::SEL_W-1:0]          i_cell_col,
    input  wire logic                                i_stall,
    output logic                                     o_valid,
    output logic [awpg_pkg::Q_W-1:0]                 o_offset,
    output logic [awpg_pkg::ST_W-1:0]                o_status
);

    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int IW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CCW   = $clog2(MAX_COLUMNS + 1);
    localparam int RCW   = $clog2(MAX_ROWS + 1);
    localparam int NW    = CCW + RCW;
    localparam int TGW   = CCW + awpg_pkg::SEL_W + 1;
    localparam int TW    = awpg_pkg::WEIGHT_W + IW;
    localparam int ACC_W = awpg_pkg::WEIGHT_W + awpg_pkg::Q_W;
    localparam int AREA_W = 2 * awpg_pkg::DIM_W;
    localparam int CDEN_W = 2 * awpg_pkg::COORD_W;
    localparam int APROD_W = awpg_pkg::PRIO_W + awpg_pkg::Q_W;
    localparam int PP_W  = awpg_pkg::PART_W + awpg_pkg::Q_W;

    // item registers
    logic [awpg_pkg::OP_W-1:0]           r_op;
    logic signed [awpg_pkg::COORD_W-1:0] r_rx;
    logic signed [awpg_pkg::COORD_W-1:0] r_ry;
    logic [awpg_pkg::COORD_W-1:0]        r_rw;
    logic [awpg_pkg::COORD_W-1:0]        r_rh;
    logic [awpg_pkg::PRIO_W-1:0]         r_prio;
    logic [TGW-1:0]                      r_tgt;
    logic [CCW-1:0]                      r_cols;
    logic [NW-1:0]                       r_n;
    logic [CDEN_W-1:0]                   r_cden;

    // walk registers
    logic [CCW-1:0]                      r_c;
    logic [RCW-1:0]                      r_r;
    logic [IW-1:0]                       r_idx;
    logic [awpg_pkg::DIM_W-1:0]          r_iw;
    logic [awpg_pkg::DIM_W-1:0]          r_ih;
    logic [AREA_W-1:0]                   r_area;
    logic [awpg_pkg::WEIGHT_W-1:0]       r_rdata;
    logic [awpg_pkg::WEIGHT_W-1:0]       r_tgtw;
    logic [TW-1:0]                       r_total;
    logic [TW-1:0]                       r_sum;
    logic [IW-1:0]                       r_clr;

    // divider and multiplier
    logic [TW-1:0]                       r_rem;
    logic [TW-1:0]                       r_den;
    logic [awpg_pkg::Q_W-1:0]            r_quo;
    logic [awpg_pkg::DCNT_W-1:0]         r_dcnt;
    logic [ACC_W-1:0]                    r_acc;
    logic [1:0]                          r_mcnt;
    logic [awpg_pkg::PRIO_W-1:0]         r_add;

    logic [awpg_pkg::WEIGHT_W-1:0]       r_mem [CELLS];

    // output register
    logic                                r_ovalid;
    logic [awpg_pkg::Q_W-1:0]            r_offset;
    logic [awpg_pkg::ST_W-1:0]           r_status;

    logic [CCW-1:0]                      n_cols;
    logic [RCW-1:0]                      n_rows;
    logic signed [awpg_pkg::GEO_W-1:0]   g_cx0, g_cx1, g_cy0, g_cy1;
    logic signed [awpg_pkg::GEO_W-1:0]   g_rx0, g_rx1, g_ry0, g_ry1;
    logic [TW-1:0]                       d_num;
    logic [TW-1:0]                       d_den;
    logic [TW:0]                         d_rem2;
    logic [awpg_pkg::PART_W-1:0]         m_part;
    logic [PP_W-1:0]                     m_pp;
    logic [ACC_W-1:0]                    m_shift;
    logic [APROD_W-1:0]                  m_aprod;
    logic [awpg_pkg::WEIGHT_W:0]         w_sum;
    logic [awpg_pkg::WEIGHT_W-1:0]       w_new;
    logic                                oor;
    logic                                grid_zero;
    logic [awpg_pkg::ST_W-1:0]           out_status;

    function automatic logic [awpg_pkg::DIM_W-1:0] f_overlap(
        input logic signed [awpg_pkg::GEO_W-1:0] a0,
        input logic signed [awpg_pkg::GEO_W-1:0] a1,
        input logic signed [awpg_pkg::GEO_W-1:0] b0,
        input logic signed [awpg_pkg::GEO_W-1:0] b1
    );
        logic signed [awpg_pkg::GEO_W-1:0] lo;
        logic signed [awpg_pkg::GEO_W-1:0] hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a1 < b1) ? a1 : b1;
        return (hi > lo) ? awpg_pkg::DIM_W'(hi - lo) : '0;
    endfunction

    // columns and rows in use, clipped to the built grid
    assign n_cols = (32'(i_grid_columns) < MAX_COLUMNS) ? CCW'(i_grid_columns)
                                                        : CCW'(MAX_COLUMNS);
    assign n_rows = (32'(i_grid_rows) < MAX_ROWS) ? RCW'(i_grid_rows)
                                                  : RCW'(MAX_ROWS);

    // cell and window edges, half open
    assign g_cx0 = $signed(awpg_pkg::GEO_W'(r_c) * awpg_pkg::GEO_W'(i_cell_width));
    assign g_cx1 = g_cx0 + $signed(awpg_pkg::GEO_W'(i_cell_width));
    assign g_cy0 = $signed(awpg_pkg::GEO_W'(r_r) * awpg_pkg::GEO_W'(i_cell_height));
    assign g_cy1 = g_cy0 + $signed(awpg_pkg::GEO_W'(i_cell_height));
    assign g_rx0 = awpg_pkg::GEO_W'(r_rx);
    assign g_rx1 = g_rx0 + $signed(awpg_pkg::GEO_W'(r_rw));
    assign g_ry0 = awpg_pkg::GEO_W'(r_ry);
    assign g_ry1 = g_ry0 + $signed(awpg_pkg::GEO_W'(r_rh));

    // divider operands: per cell ratio or final share
    always_comb begin
        if (i_cmd.fstart) begin
            d_num = (r_op == awpg_pkg::OP_RECT) ? r_sum : TW'(r_tgtw);
            d_den = r_total;
        end else begin
            d_num = TW'(r_area);
            d_den = TW'(r_cden);
        end
    end

    assign d_rem2 = {r_rem, 1'b0};

    // one 16 bit slice of the weight per multiply step
    always_comb begin
        case (r_mcnt)
            2'd0: begin
                m_part  = r_rdata[awpg_pkg::PART_W-1:0];
                m_pp    = PP_W'(m_part) * PP_W'(r_quo);
                m_shift = ACC_W'(m_pp);
            end
            2'd1: begin
                m_part  = r_rdata[2*awpg_pkg::PART_W-1:awpg_pkg::PART_W];
                m_pp    = PP_W'(m_part) * PP_W'(r_quo);
                m_shift = ACC_W'(m_pp) << awpg_pkg::PART_W;
            end
            default: begin
                m_part  = r_rdata[3*awpg_pkg::PART_W-1:2*awpg_pkg::PART_W];
                m_pp    = PP_W'(m_part) * PP_W'(r_quo);
                m_shift = ACC_W'(m_pp) << (2 * awpg_pkg::PART_W);
            end
        endcase
    end

    assign m_aprod = APROD_W'(r_prio) * APROD_W'(r_quo);

    // saturating weight update
    assign w_sum = {1'b0, r_rdata} + (awpg_pkg::WEIGHT_W + 1)'(r_add);
    assign w_new = w_sum[awpg_pkg::WEIGHT_W] ? '1 : w_sum[awpg_pkg::WEIGHT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op   <= i_opcode;
            r_rx   <= i_rect_x;
            r_ry   <= i_rect_y;
            r_rw   <= i_rect_width;
            r_rh   <= i_rect_height;
            r_prio <= i_priority_req;
            r_cols <= n_cols;
            r_n    <= NW'(n_cols) * NW'(n_rows);
            r_tgt  <= TGW'(i_cell_col) + TGW'(n_cols) * TGW'(i_cell_row);
            r_cden <= (i_opcode == awpg_pkg::OP_ADD)
                    ? CDEN_W'(i_rect_width) * CDEN_W'(i_rect_height)
                    : CDEN_W'(i_cell_width) * CDEN_W'(i_cell_height);
            r_c     <= '0;
            r_r     <= '0;
            r_idx   <= '0;
            r_total <= '0;
            r_sum   <= '0;
        end
        if (i_cmd.rd) begin
            r_iw <= f_overlap(g_cx0, g_cx1, g_rx0, g_rx1);
            r_ih <= f_overlap(g_cy0, g_cy1, g_ry0, g_ry1);
        end
        if (i_cmd.area) begin
            r_area  <= AREA_W'(r_iw) * AREA_W'(r_ih);
            r_total <= r_total + TW'(r_rdata);
            if (TGW'(r_idx) == r_tgt) r_tgtw <= r_rdata;
        end
        if (i_cmd.dstart || i_cmd.fstart) begin
            r_den <= d_den;
            if (d_num >= d_den) begin
                r_quo  <= awpg_pkg::ONE_Q;
                r_dcnt <= awpg_pkg::DCNT_W'(awpg_pkg::DIV_STEPS);
            end else begin
                r_rem  <= d_num;
                r_quo  <= '0;
                r_dcnt <= '0;
            end
            r_acc  <= '0;
            r_mcnt <= '0;
        end
        if (i_cmd.dstep) begin
            if (d_rem2 >= {1'b0, r_den}) begin
                r_rem <= TW'(d_rem2 - {1'b0, r_den});
                r_quo <= {r_quo[awpg_pkg::Q_W-2:0], 1'b1};
            end else begin
                r_rem <= TW'(d_rem2);
                r_quo <= {r_quo[awpg_pkg::Q_W-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.mstep) begin
            r_add  <= m_aprod[awpg_pkg::FRAC_W +: awpg_pkg::PRIO_W];
            r_acc  <= r_acc + m_shift;
            r_mcnt <= r_mcnt + 1'b1;
        end
        if (i_cmd.wb && r_op == awpg_pkg::OP_RECT) begin
            r_sum <= r_sum + TW'(r_acc[ACC_W-1:awpg_pkg::FRAC_W]);
        end
        if (i_cmd.next) begin
            r_idx <= r_idx + 1'b1;
            if (r_c == r_cols - 1'b1) begin
                r_c <= '0;
                r_r <= r_r + 1'b1;
            end else begin
                r_c <= r_c + 1'b1;
            end
        end
    end

    // weight memory, one port, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_clr] <= '0;
        end else if (i_cmd.wb && r_op == awpg_pkg::OP_ADD) begin
            r_mem[r_idx] <= w_new;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    assign oor       = (r_op == awpg_pkg::OP_CELL) && (r_tgt >= TGW'(r_n));
    assign grid_zero = (r_total == '0);

    always_comb begin
        if (oor) begin
            out_status = awpg_pkg::ST_RANGE;
        end else if ((r_op == awpg_pkg::OP_RECT || r_op == awpg_pkg::OP_CELL) &&
                     grid_zero) begin
            out_status = awpg_pkg::ST_ZERO;
        end else begin
            out_status = awpg_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status <= out_status;
            r_offset <= ((r_op == awpg_pkg::OP_RECT || r_op == awpg_pkg::OP_CELL) &&
                         out_status == awpg_pkg::ST_OK) ? r_quo : '0;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_offset = r_offset;
    assign o_status = r_status;

    assign o_sts.op           = r_op;
    assign o_sts.clr_last     = (32'(r_clr) == CELLS - 1);
    assign o_sts.out_of_range = oor;
    assign o_sts.empty_grid   = (r_n == '0);
    assign o_sts.overlap      = (r_iw != '0) && (r_ih != '0);
    assign o_sts.div_done     = (r_dcnt == awpg_pkg::DCNT_W'(awpg_pkg::DIV_STEPS));
    assign o_sts.mul_last     = (r_op == awpg_pkg::OP_ADD) ||
                                (r_mcnt == 2'(awpg_pkg::MUL_PARTS - 1));
    assign o_sts.last_cell    = ((NW'(r_idx) + 1'b1) == r_n);
    assign o_sts.total_zero   = grid_zero;
    assign o_sts.out_free     = !r_ovalid || !i_stall;

endmodule

`default_nettype wire

[test/area_weighted_priority_grid_unit_tb.sv]
// testbench for area_weighted_priority_grid_unit: directed and random items
// checked against an in-bench grid predictor; depends on awpg_pkg and the rtl
`default_nettype none

module area_weighted_priority_grid_unit_tb;

    localparam int COLS_MAX = 16;
    localparam int ROWS_MAX = 16;
    localparam int CELLS    = COLS_MAX * ROWS_MAX;
    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam logic [63:0] WEIGHT_SAT = (64'd1 << 48) - 64'd1;

    typedef struct packed {
        logic [awpg_pkg::OP_W-1:0]           op;
        logic signed [awpg_pkg::COORD_W-1:0] rx;
        logic signed [awpg_pkg::COORD_W-1:0] ry;
        logic [awpg_pkg::COORD_W-1:0]        rw;
        logic [awpg_pkg::COORD_W-1:0]        rh;
        logic [awpg_pkg::PRIO_W-1:0]         prio;
        logic [awpg_pkg::SEL_W-1:0]          row;
        logic [awpg_pkg::SEL_W-1:0]          col;
    } t_grid_item;

    typedef struct packed {
        logic [awpg_pkg::Q_W-1:0]  offset;
        logic [awpg_pkg::ST_W-1:0] status;
    } t_share;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel, penable, pwrite;
    logic [awpg_pkg::PADDR_W-1:0]    paddr;
    logic [awpg_pkg::PDATA_W-1:0]    pwdata;
    logic [awpg_pkg::PDATA_W-1:0]    prdata;
    logic                            pready;
    logic                            i_valid;
    logic                            o_stall;
    t_grid_item                      drv;
    logic                            o_valid;
    logic                            i_stall;
    logic [awpg_pkg::Q_W-1:0]        o_offset;
    logic [awpg_pkg::ST_W-1:0]       o_status;

    // predictor state
    logic [63:0] weight_mirror [CELLS];
    logic [12:0] cfg_cw, cfg_ch;
    logic [4:0]  cfg_cols, cfg_rows;

    t_share share_queue[$];
    int     fail_count;
    int     items_sent;
    int     results_seen;
    int     stall_pct;
    longint cycle_count;

    area_weighted_priority_grid_unit #(
        .MAX_COLUMNS(COLS_MAX),
        .MAX_ROWS   (ROWS_MAX)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (drv.op),
        .i_rect_x      (drv.rx),
        .i_rect_y      (drv.ry),
        .i_rect_width  (drv.rw),
        .i_rect_height (drv.rh),
        .i_priority_req(drv.prio),
        .i_cell_row    (drv.row),
        .i_cell_col    (drv.col),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_offset      (o_offset),
        .o_status      (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // floor(num * 2^16 / den) saturated at one
    function automatic logic [63:0] frac_q16(logic [63:0] num, logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] q;
        rem = num;
        q = 0;
        if (num >= den) return 64'(awpg_pkg::ONE_Q);
        for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic longint span_overlap(longint a0, longint al, longint b0, longint bl);
        longint lo, hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a0 + al < b0 + bl) ? a0 + al : b0 + bl;
        return (hi > lo) ? hi - lo : 0;
    endfunction

    function automatic t_share grid_predict(t_grid_item it);
        t_share      res;
        longint      cols, rows, rx, ry, rw, rh, iw, ih;
        logic [63:0] total, sum, area, ratio, w, add, idx;
        res = '0;
        cols = (cfg_cols < COLS_MAX) ? cfg_cols : COLS_MAX;
        rows = (cfg_rows < ROWS_MAX) ? cfg_rows : ROWS_MAX;
        rx = longint'(it.rx);
        ry = longint'(it.ry);
        rw = longint'(it.rw);
        rh = longint'(it.rh);
        total = 0;
        sum = 0;
        for (int i = 0; i < cols * rows; i++) total += weight_mirror[i];
        case (it.op)
            awpg_pkg::OP_ADD: begin
                if (rw > 0 && rh > 0) begin
                    area = rw * rh;
                    for (longint r = 0; r < rows; r++) begin
                        for (longint c = 0; c < cols; c++) begin
                            iw = span_overlap(c * cfg_cw, cfg_cw, rx, rw);
                            ih = span_overlap(r * cfg_ch, cfg_ch, ry, rh);
                            if (iw > 0 && ih > 0) begin
                                ratio = frac_q16(iw * ih, area);
                                add = (it.prio * ratio) >> 16;
                                w = weight_mirror[c + cols * r];
                                w = (WEIGHT_SAT - w < add) ? WEIGHT_SAT : w + add;
                                weight_mirror[c + cols * r] = w;
                            end
                        end
                    end
                end
            end
            awpg_pkg::OP_RECT: begin
                area = 64'(cfg_cw) * 64'(cfg_ch);
                if (rw > 0 && rh > 0 && area != 0) begin
                    for (longint r = 0; r < rows; r++) begin
                        for (longint c = 0; c < cols; c++) begin
                            iw = span_overlap(c * cfg_cw, cfg_cw, rx, rw);
                            ih = span_overlap(r * cfg_ch, cfg_ch, ry, rh);
                            if (iw > 0 && ih > 0) begin
                                ratio = frac_q16(iw * ih, area);
                                sum += (weight_mirror[c + cols * r] * ratio) >> 16;
                            end
                        end
                    end
                end
                if (total == 0) res.status = awpg_pkg::ST_ZERO;
                else res.offset = awpg_pkg::Q_W'(frac_q16(sum, total));
            end
            awpg_pkg::OP_CELL: begin
                idx = 64'(it.col) + 64'(cols) * 64'(it.row);
                if (idx >= cols * rows) res.status = awpg_pkg::ST_RANGE;
                else if (total == 0) res.status = awpg_pkg::ST_ZERO;
                else res.offset = awpg_pkg::Q_W'(frac_q16(weight_mirror[idx], total));
            end
            default: ;
        endcase
        return res;
    endfunction

    // receiver stall pattern, density set per phase
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen <= results_seen + 1;
            if (share_queue.size() == 0) begin
                $error("result with nothing expected: offset %0d status %0d",
                       o_offset, o_status);
                fail_count++;
            end else begin
                t_share exp_r;
                exp_r = share_queue.pop_front();
                if (o_offset !== exp_r.offset) begin
                    $error("offset expected %0d actual %0d", exp_r.offset, o_offset);
                    fail_count++;
                end
                if (o_status !== exp_r.status) begin
                    $error("status expected %0d actual %0d", exp_r.status, o_status);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_item(t_grid_item it);
        @(negedge i_clk);
        drv = it;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        share_queue.insert(share_queue.size(), grid_predict(it));
        items_sent++;
        // sender bursts: sometimes drop valid for a random gap
        if ($urandom_range(3) == 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat ($urandom_range(6)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (share_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] regno, logic [awpg_pkg::PDATA_W-1:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {regno, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (regno)
            awpg_pkg::REG_CELL_WIDTH:  cfg_cw = value[12:0];
            awpg_pkg::REG_CELL_HEIGHT: cfg_ch = value[12:0];
            awpg_pkg::REG_GRID_COLS:   cfg_cols = value[4:0];
            default:                   cfg_rows = value[4:0];
        endcase
    endtask

    task automatic set_grid(int cw, int ch, int cols, int rows);
        wait_drain();
        reg_write(awpg_pkg::REG_CELL_WIDTH, cw);
        reg_write(awpg_pkg::REG_CELL_HEIGHT, ch);
        reg_write(awpg_pkg::REG_GRID_COLS, cols);
        reg_write(awpg_pkg::REG_GRID_ROWS, rows);
    endtask

    function automatic t_grid_item mk(logic [1:0] op, int x, int y, int w, int h,
                                      int p, int row, int col);
        t_grid_item it;
        it.op = op;
        it.rx = x[15:0];
        it.ry = y[15:0];
        it.rw = w[15:0];
        it.rh = h[15:0];
        it.prio = p[23:0];
        it.row = row[7:0];
        it.col = col[7:0];
        return it;
    endfunction

    function automatic t_grid_item random_item();
        t_grid_item   it;
        logic [127:0] raw;
        int span_x, span_y, k;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_grid_item)-1:0];
        k = $urandom_range(99);
        it.op = (k < 40) ? awpg_pkg::OP_ADD : (k < 70) ? awpg_pkg::OP_RECT :
                (k < 95) ? awpg_pkg::OP_CELL : awpg_pkg::OP_NONE;
        span_x = cfg_cw * ((cfg_cols < COLS_MAX) ? cfg_cols : COLS_MAX) + 1;
        span_y = cfg_ch * ((cfg_rows < ROWS_MAX) ? cfg_rows : ROWS_MAX) + 1;
        // mostly windows placed on the grid with a few cells each
        if ($urandom_range(9) != 0) begin
            it.rx = 16'(int'($urandom_range(span_x)) - int'(cfg_cw));
            it.ry = 16'(int'($urandom_range(span_y)) - int'(cfg_ch));
            it.rw = 16'($urandom_range(3 * cfg_cw + 1));
            it.rh = 16'($urandom_range(3 * cfg_ch + 1));
            if ($urandom_range(15) == 0) it.rw = 0;
        end
        if ($urandom_range(3) != 0) begin
            it.row = 8'($urandom_range(17));
            it.col = 8'($urandom_range(17));
        end
        return it;
    endfunction

    task automatic test_directed();
        send_item(mk(awpg_pkg::OP_RECT, 0, 0, 4096, 4096, 0, 0, 0));     // zero total
        send_item(mk(awpg_pkg::OP_CELL, 0, 0, 0, 0, 0, 0, 0));           // zero total
        send_item(mk(awpg_pkg::OP_CELL, 0, 0, 0, 0, 0, 16, 0));          // out of range
        send_item(mk(awpg_pkg::OP_CELL, 0, 0, 0, 0, 0, 255, 255));
        send_item(mk(awpg_pkg::OP_ADD, 0, 0, 4096, 4096, 16777215, 0, 0));
        send_item(mk(awpg_pkg::OP_ADD, 100, 100, 0, 50, 16777215, 0, 0)); // empty window
        send_item(mk(awpg_pkg::OP_ADD, 100, 100, 50, 0, 16777215, 0, 0));
        send_item(mk(awpg_pkg::OP_ADD, -32768, -32768, 65535, 65535, 65536, 0, 0));
        send_item(mk(awpg_pkg::OP_ADD, 32767, 32767, 65535, 65535, 65536, 0, 0));
        send_item(mk(awpg_pkg::OP_ADD, 10, 20, 300, 200, 0, 0, 0));
        send_item(mk(awpg_pkg::OP_ADD, 200, 300, 600, 100, 12345678, 0, 0));
        send_item(mk(awpg_pkg::OP_NONE, -1, -1, 65535, 65535, 16777215, 255, 255));
        send_item(mk(awpg_pkg::OP_CELL, 0, 0, 0, 0, 0, 0, 255));         // column runs on
        send_item(mk(awpg_pkg::OP_CELL, 0, 0, 0, 0, 0, 15, 15));
        send_item(mk(awpg_pkg::OP_CELL, 0, 0, 0, 0, 0, 1, 1));
        send_item(mk(awpg_pkg::OP_RECT, 0, 0, 4096, 4096, 0, 0, 0));
        send_item(mk(awpg_pkg::OP_RECT, 128, 128, 256, 256, 0, 0, 0));
        send_item(mk(awpg_pkg::OP_RECT, 0, 0, 0, 4096, 0, 0, 0));        // empty query
        send_item(mk(awpg_pkg::OP_RECT, -32768, -32768, 65535, 65535, 0, 0, 0));
        send_item(mk(awpg_pkg::OP_RECT, 5000, 5000, 10, 10, 0, 0, 0));
    endtask

    task automatic test_random(int count, int pct);
        stall_pct = pct;
        for (int n = 0; n < count; n++) begin
            send_item(random_item());
            if (n == count / 2) wait_drain();    // let everything come back mid phase
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        drv = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_stall = 1'b0;
        stall_pct = 0;
        fail_count = 0;
        items_sent = 0;
        results_seen = 0;
        cycle_count = 0;
        cfg_cw = 256;
        cfg_ch = 256;
        cfg_cols = 16;
        cfg_rows = 16;
        foreach (weight_mirror[i]) weight_mirror[i] = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        stall_pct = 30;
        test_directed();
        test_random(30, 0);
        set_grid(64, 32, 4, 4);
        test_random(120, 40);
        set_grid(1, 1, 8, 8);
        test_random(50, 70);
        set_grid(4096, 4096, 2, 3);
        test_random(50, 20);
        set_grid(100, 37, 20, 31);
        test_random(40, 50);
        set_grid(0, 50, 4, 4);
        test_random(20, 10);
        set_grid(13, 7, 0, 5);
        test_random(15, 30);
        set_grid(8191, 8191, 1, 1);
        test_random(30, 60);
        set_grid(1, 8191, 16, 1);
        test_random(30, 0);

        wait_drain();
        $display("covered %0d items and %0d results over nine grid settings", items_sent,
                 results_seen);
        $display("settings ranged over zero, unit, largest and clamped sizes");
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
